### rtl/rwhc_pkg.sv
// Shared types, constants and byte tables for the RIFF/WAVE header checker.
// No dependencies; used by rwhc_parser and riff_wave_header_checker.
package rwhc_pkg;

    // Parse phases.
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHUNK  = 3'd1;
    localparam logic [2:0] PH_FMT    = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_IO          = 2'd3;

    localparam logic [31:0] SIZE_LIMIT    = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_FILE_SIZE = 32'd12;
    localparam logic [31:0] HEADER_BYTES  = 32'd12;
    localparam logic [31:0] CHUNK_HDR     = 32'd8;
    localparam logic [31:0] FMT_BODY      = 32'd16;

    // Chunk tags as collected little-endian.
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int MAX_CHUNKS_DEF = 64;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [30:0] data_offset;
        logic [30:0] data_size;
    } rwhc_result_t;

    // Fixed bytes of the RIFF header; the size field bytes are not compared.
    function automatic logic [7:0] riff_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h52;
            4'd1:    v = 8'h49;
            4'd2:    v = 8'h46;
            4'd3:    v = 8'h46;
            4'd8:    v = 8'h57;
            4'd9:    v = 8'h41;
            4'd10:   v = 8'h56;
            4'd11:   v = 8'h45;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // The only accepted fmt body: PCM, mono, 16000 Hz, 32000 B/s, align 2, 16 bits.
    function automatic logic [7:0] fmt_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h01;
            4'd2:    v = 8'h01;
            4'd4:    v = 8'h80;
            4'd5:    v = 8'h3E;
            4'd9:    v = 8'h7D;
            4'd12:   v = 8'h02;
            4'd14:   v = 8'h10;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### rtl/rwhc_parser.sv
// Byte-at-a-time RIFF/WAVE parse state and its combinational next-state logic.
// Depends on rwhc_pkg.
module rwhc_parser
    import rwhc_pkg::*;
#(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   data_byte,
    input  logic         last,
    input  logic [31:0]  file_size,
    output rwhc_result_t result
);

    localparam logic [7:0] MAX_CHUNKS_B = 8'(MAX_CHUNKS);

    logic [31:0] pos_reg, pos_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [7:0]  chunks_reg, chunks_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic [30:0] offset_reg, offset_next;
    logic [30:0] size_reg, size_next;
    logic [1:0]  err_reg, err_next;

    logic [31:0] pos_inc;
    logic [31:0] room;
    logic        past_end;
    logic [31:0] shift_in;
    logic [31:0] tag_in;
    logic [31:0] rem_dec;
    logic [3:0]  fmt_idx;
    logic        do_start;

    assign pos_inc  = pos_reg + 32'd1;
    assign past_end = pos_inc >= file_size;
    assign room     = past_end ? 32'd0 : file_size - pos_inc;
    assign shift_in = {data_byte, shift_reg[31:8]};
    assign tag_in   = {data_byte, tag_reg[31:8]};
    assign rem_dec  = remaining_reg - 32'd1;
    assign fmt_idx  = 4'd0 - remaining_reg[3:0];

    always_comb
    begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        tag_next       = tag_reg;
        remaining_next = remaining_reg;
        chunks_next    = chunks_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        offset_next    = offset_reg;
        size_next      = size_reg;
        err_next       = err_reg;
        do_start       = 1'b0;
        result         = '0;

        if (fire)
        begin
            if (err_next == ST_OK && (file_size < MIN_FILE_SIZE || file_size > SIZE_LIMIT))
            begin
                err_next = ST_INVALID;
            end
            if (err_next == ST_OK)
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        pos_next = pos_inc;
                        if (pos_reg[3:2] == 2'b01)
                        begin
                            shift_next = shift_in;
                        end
                        else if (data_byte != riff_byte(pos_reg[3:0]))
                        begin
                            tag_next = 32'd1;
                        end
                        if (pos_inc >= HEADER_BYTES)
                        begin
                            if (tag_next != 32'd0 || shift_next != file_size - CHUNK_HDR)
                                err_next = ST_INVALID;
                            else
                                do_start = 1'b1;
                        end
                    end
                    PH_CHUNK:
                    begin
                        pos_next = pos_inc;
                        if (remaining_reg > 32'd4)
                            tag_next = tag_in;
                        else
                            shift_next = shift_in;
                        remaining_next = rem_dec;
                        if (rem_dec == 32'd0)
                        begin
                            // Chunk header complete: body plus pad byte must fit.
                            if (shift_in > room || (shift_in[0] && shift_in == room))
                            begin
                                err_next = ST_INVALID;
                            end
                            else if (tag_reg == TAG_FMT)
                            begin
                                if (fmt_seen_reg || shift_in < FMT_BODY)
                                begin
                                    err_next = ST_INVALID;
                                end
                                else
                                begin
                                    phase_next     = PH_FMT;
                                    remaining_next = FMT_BODY;
                                    tag_next       = 32'd0;
                                end
                            end
                            else if (tag_reg == TAG_DATA && (data_seen_reg || shift_in[0]))
                            begin
                                err_next = ST_INVALID;
                            end
                            else
                            begin
                                if (tag_reg == TAG_DATA)
                                begin
                                    data_seen_next = 1'b1;
                                    offset_next    = pos_inc[30:0];
                                    size_next      = shift_in[30:0];
                                end
                                remaining_next = shift_in + {31'd0, shift_in[0]};
                                phase_next     = PH_SKIP;
                                if (shift_in == 32'd0)
                                    do_start = 1'b1;
                            end
                        end
                    end
                    PH_FMT:
                    begin
                        pos_next = pos_inc;
                        if (data_byte != fmt_byte(fmt_idx))
                            tag_next = 32'd1;
                        remaining_next = rem_dec;
                        if (rem_dec == 32'd0)
                        begin
                            if (tag_next != 32'd0 || shift_reg != FMT_BODY)
                            begin
                                err_next = ST_UNSUPPORTED;
                            end
                            else
                            begin
                                fmt_seen_next = 1'b1;
                                do_start      = 1'b1;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        pos_next = pos_inc;
                        if (remaining_reg != 32'd0)
                            remaining_next = rem_dec;
                        if (remaining_next == 32'd0)
                            do_start = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                // Start of the next chunk, or the end of the walk.
                if (do_start)
                begin
                    if (past_end)
                    begin
                        if (!fmt_seen_next || !data_seen_next)
                            err_next = ST_INVALID;
                        else
                            phase_next = PH_DONE;
                    end
                    else if (chunks_reg >= MAX_CHUNKS_B || room < CHUNK_HDR)
                    begin
                        err_next = ST_INVALID;
                    end
                    else
                    begin
                        chunks_next    = chunks_reg + 8'd1;
                        phase_next     = PH_CHUNK;
                        remaining_next = CHUNK_HDR;
                        tag_next       = 32'd0;
                        shift_next     = 32'd0;
                    end
                end
            end

            if (last)
            begin
                result.valid = 1'b1;
                if (err_next != ST_OK)
                    result.status = err_next;
                else if (phase_next != PH_DONE)
                    result.status = ST_IO;
                else
                    result.status = ST_OK;
                if (result.status == ST_OK)
                begin
                    result.data_offset = offset_next;
                    result.data_size   = size_next;
                end
                pos_next       = '0;
                phase_next     = PH_HEADER;
                shift_next     = '0;
                tag_next       = '0;
                remaining_next = '0;
                chunks_next    = '0;
                fmt_seen_next  = 1'b0;
                data_seen_next = 1'b0;
                offset_next    = '0;
                size_next      = '0;
                err_next       = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= PH_HEADER;
            shift_reg     <= '0;
            tag_reg       <= '0;
            remaining_reg <= '0;
            chunks_reg    <= '0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            offset_reg    <= '0;
            size_reg      <= '0;
            err_reg       <= ST_OK;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            tag_reg       <= tag_next;
            remaining_reg <= remaining_next;
            chunks_reg    <= chunks_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            offset_reg    <= offset_next;
            size_reg      <= size_next;
            err_reg       <= err_next;
        end
    end

    // A latched error holds until the stream's last byte clears it.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last && err_reg != ST_OK |=> err_reg == $past(err_reg))
        else $error("latched error changed mid-stream");

    // A recorded data chunk always implies the walk counted at least one chunk.
    assert property (@(posedge clk) disable iff (!rst_n)
        data_seen_reg |-> chunks_reg != 8'd0)
        else $error("data chunk recorded without a chunk count");

endmodule

### rtl/riff_wave_header_checker.sv
// Top level of the RIFF/WAVE header checker: input register, parser, result register.
// Depends on rwhc_pkg and rwhc_parser.
//
//  Channel   Handshake              Payload
//  -------   --------------------   ---------------------------------
//  input     in_valid / in_ready    data_byte[7:0], last
//  result    out_valid / out_ready  status[1:0], data_offset[30:0], data_size[30:0]
//  config    cfg_we                 cfg_wdata[31:0] (file size)
//
// One byte per cycle is sustained while the input register does not stall; each byte is
// parsed from the input register, and the last byte's result loads the result register.
// The input register stalls only when a last byte meets a full, unread result register.
// Reset clears the parse state, both pipeline registers and the file size.
module riff_wave_header_checker
    import rwhc_pkg::*;
#(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [30:0] data_offset,
    output logic [30:0] data_size,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic [31:0]  file_size_reg;
    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    logic         s1_last_reg;
    logic         s1_fire;
    logic         out_free;
    logic         out_valid_reg;
    logic [1:0]   status_reg;
    logic [30:0]  offset_reg;
    logic [30:0]  size_reg;
    rwhc_result_t result;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            file_size_reg <= '0;
        else if (cfg_we)
            file_size_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_byte_reg  <= '0;
            s1_last_reg  <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
            s1_byte_reg  <= data_byte;
            s1_last_reg  <= last;
        end
    end

    rwhc_parser #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .data_byte (s1_byte_reg),
        .last      (s1_last_reg),
        .file_size (file_size_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            offset_reg    <= '0;
            size_reg      <= '0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
            status_reg    <= result.status;
            offset_reg    <= result.data_offset;
            size_reg      <= result.data_size;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data_offset = offset_reg;
    assign data_size   = size_reg;

    // A new result may only load when the result register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> out_free)
        else $error("result overwrote an untransferred result");

    // The input side stalls only while a byte marked last is held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_last_reg)
        else $error("input stalled without a pending last byte");

    // Offset and size are reported only with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> offset_reg == '0 && size_reg == '0)
        else $error("nonzero offset or size on a failing status");

endmodule
